// File: rtl/core/gti_pkg.sv
package gti_pkg;

  localparam int unsigned DEF_TABLE_DEPTH      = 1024;
  localparam int unsigned DEF_MAX_AXIS_SAMPLES = 64;

  // write opcode and query opcode of an input transaction
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_READY = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [2:0] CFG_SPEED_STEP     = 3'd0;
  localparam logic [2:0] CFG_SPEED_STEP_INV = 3'd1;
  localparam logic [2:0] CFG_ANGLE_STEP     = 3'd2;
  localparam logic [2:0] CFG_ANGLE_STEP_INV = 3'd3;
  localparam logic [2:0] CFG_SPEED_SAMPLES  = 3'd4;
  localparam logic [2:0] CFG_ANGLE_SAMPLES  = 3'd5;
  localparam logic [2:0] CFG_TABLE_READY    = 3'd6;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         entry_speed_index;
    logic [5:0]         entry_angle_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_speed;
    logic signed [31:0] query_angle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic signed [31:0] speed_slope;
    logic signed [31:0] angle_slope;
  } out_item_t;

  // effective grid geometry, already sanitized
  typedef struct packed {
    logic [30:0] speed_step;
    logic [30:0] speed_inv;
    logic [30:0] angle_step;
    logic [30:0] angle_inv;
    logic [6:0]  speed_n;
    logic [6:0]  angle_n;
  } axis_cfg_t;

  typedef struct packed {
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic               wide;
  } pick_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    if (x[66:31] == '0 || x[66:31] == '1) begin
      return x[31:0];
    end else if (x[66]) begin
      return 32'sh8000_0000;
    end
    return 32'sh7fff_ffff;
  endfunction

  // finite difference operands: one-sided at an edge, central inside
  function automatic pick_t slope_pick(input logic at_lo, input logic at_hi,
                                       input logic signed [31:0] wm,
                                       input logic signed [31:0] w0,
                                       input logic signed [31:0] wp);
    pick_t p;
    p.hi   = wp;
    p.lo   = wm;
    p.wide = 1'b1;
    if (at_lo) begin
      p.lo   = w0;
      p.wide = 1'b0;
    end else if (at_hi) begin
      p.hi   = w0;
      p.wide = 1'b0;
    end
    return p;
  endfunction

endpackage

// File: rtl/core/gti_ram.sv
module gti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gti_engine.sv
module gti_engine #(
  parameter int unsigned TABLE_DEPTH = gti_pkg::DEF_TABLE_DEPTH,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  qs_i,
  input  logic signed [31:0]  qa_i,
  input  gti_pkg::axis_cfg_t  cfg_i,
  output logic [AW-1:0]       rd_addr_o,
  input  logic [31:0]         rd_data_i,
  output logic                busy_o,
  output logic                done_o,
  output gti_pkg::out_item_t  result_o
);
  import gti_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam logic [5:0] STEP_SI   = 6'd0;
  localparam logic [5:0] STEP_AI   = 6'd1;
  localparam logic [5:0] STEP_FS   = 6'd2;
  localparam logic [5:0] STEP_FA   = 6'd3;
  localparam logic [5:0] STEP_RD0  = 6'd4;
  localparam logic [5:0] STEP_RD15 = 6'd19;
  localparam logic [5:0] STEP_CP0  = 6'd5;
  localparam logic [5:0] STEP_CP15 = 6'd20;
  localparam logic [5:0] STEP_CS0  = 6'd21;
  localparam logic [5:0] STEP_CS1  = 6'd22;
  localparam logic [5:0] STEP_CS2  = 6'd23;
  localparam logic [5:0] STEP_CA0  = 6'd24;
  localparam logic [5:0] STEP_CA1  = 6'd25;
  localparam logic [5:0] STEP_CA2  = 6'd26;
  localparam logic [5:0] STEP_L0A  = 6'd27;
  localparam logic [5:0] STEP_L0S  = 6'd28;
  localparam logic [5:0] STEP_L1A  = 6'd29;
  localparam logic [5:0] STEP_L1S  = 6'd30;
  localparam logic [5:0] STEP_L2A  = 6'd31;
  localparam logic [5:0] STEP_L2S  = 6'd32;
  localparam logic [5:0] STEP_T0A  = 6'd33;
  localparam logic [5:0] STEP_T0S  = 6'd34;
  localparam logic [5:0] STEP_T1A  = 6'd35;
  localparam logic [5:0] STEP_T1S  = 6'd36;
  localparam logic [5:0] STEP_T2A  = 6'd37;
  localparam logic [5:0] STEP_T2S  = 6'd38;
  localparam logic [5:0] STEP_FIN  = 6'd40;

  localparam logic [13:0] DEPTH_LIM = 14'(TABLE_DEPTH);

  state_e             state_q, state_d;
  logic [5:0]         step_q, step_d;
  logic signed [31:0] qs_q, qa_q;
  logic [5:0]         si_q, ai_q;
  logic signed [31:0] fs_q, fa_q;
  logic               fault_q;
  logic signed [31:0] w_q [16];
  logic signed [31:0] cs_q [3];
  logic signed [31:0] ca_q [3];
  logic signed [31:0] ls_q [6];
  logic signed [47:0] t_q [6];
  logic signed [66:0] prod_q, prod_d;
  logic [5:0]         issue_q;
  logic               prod_vld_q;
  logic               wide_q, wide_d;

  logic signed [33:0] op_a;
  logic signed [32:0] op_b;
  pick_t              pk;

  logic [6:0] sn_m1, an_m1;
  logic       si_lo, si_hi, si1_hi, ai_lo, ai_hi, ai1_hi;

  assign sn_m1  = cfg_i.speed_n - 7'd1;
  assign an_m1  = cfg_i.angle_n - 7'd1;
  assign si_lo  = (si_q == 6'd0);
  assign si_hi  = (7'(si_q) == sn_m1);
  assign si1_hi = (7'(si_q) + 7'd1 == sn_m1);
  assign ai_lo  = (ai_q == 6'd0);
  assign ai_hi  = (7'(ai_q) == an_m1);
  assign ai1_hi = (7'(ai_q) + 7'd1 == an_m1);

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          step_d  = STEP_SI;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_FIN) begin
          state_d = ST_IDLE;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      prod_vld_q <= (state_q == ST_RUN);
    end
  end

  // shared multiplier operand selection
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    wide_d = 1'b0;
    pk     = '0;
    case (step_q)
      STEP_SI: begin
        op_a = 34'(qs_q);
        op_b = 33'(cfg_i.speed_inv);
      end
      STEP_AI: begin
        op_a = 34'(qa_q);
        op_b = 33'(cfg_i.angle_inv);
      end
      STEP_FS: begin
        op_a = 34'(si_q);
        op_b = 33'(cfg_i.speed_step);
      end
      STEP_FA: begin
        op_a = 34'(ai_q);
        op_b = 33'(cfg_i.angle_step);
      end
      STEP_CS0: pk = slope_pick(si_lo, si_hi, w_q[1], w_q[5], w_q[9]);
      STEP_CS1: pk = slope_pick(si_lo, si_hi, w_q[2], w_q[6], w_q[10]);
      STEP_CS2: pk = slope_pick(1'b0, si1_hi, w_q[5], w_q[9], w_q[13]);
      STEP_CA0: pk = slope_pick(ai_lo, ai_hi, w_q[4], w_q[5], w_q[6]);
      STEP_CA1: pk = slope_pick(1'b0, ai1_hi, w_q[5], w_q[6], w_q[7]);
      STEP_CA2: pk = slope_pick(ai_lo, ai_hi, w_q[8], w_q[9], w_q[10]);
      STEP_L0A: begin
        op_a = 34'(w_q[6]) - 34'(w_q[5]);
        op_b = 33'(cfg_i.angle_inv);
      end
      STEP_L0S: begin
        op_a = 34'(w_q[9]) - 34'(w_q[5]);
        op_b = 33'(cfg_i.speed_inv);
      end
      STEP_L1A: begin
        op_a = 34'(cs_q[1]) - 34'(cs_q[0]);
        op_b = 33'(cfg_i.angle_inv);
      end
      STEP_L1S: begin
        op_a = 34'(cs_q[2]) - 34'(cs_q[0]);
        op_b = 33'(cfg_i.speed_inv);
      end
      STEP_L2A: begin
        op_a = 34'(ca_q[1]) - 34'(ca_q[0]);
        op_b = 33'(cfg_i.angle_inv);
      end
      STEP_L2S: begin
        op_a = 34'(ca_q[2]) - 34'(ca_q[0]);
        op_b = 33'(cfg_i.speed_inv);
      end
      STEP_T0A: begin
        op_a = 34'(ls_q[0]);
        op_b = 33'(fa_q);
      end
      STEP_T0S: begin
        op_a = 34'(ls_q[1]);
        op_b = 33'(fs_q);
      end
      STEP_T1A: begin
        op_a = 34'(ls_q[2]);
        op_b = 33'(fa_q);
      end
      STEP_T1S: begin
        op_a = 34'(ls_q[3]);
        op_b = 33'(fs_q);
      end
      STEP_T2A: begin
        op_a = 34'(ls_q[4]);
        op_b = 33'(fa_q);
      end
      STEP_T2S: begin
        op_a = 34'(ls_q[5]);
        op_b = 33'(fs_q);
      end
      default: ;
    endcase
    // cell slope steps take the picked difference
    if (step_q >= STEP_CS0 && step_q <= STEP_CA2) begin
      op_a   = 34'(pk.hi) - 34'(pk.lo);
      op_b   = (step_q <= STEP_CS2) ? 33'(cfg_i.speed_inv) : 33'(cfg_i.angle_inv);
      wide_d = pk.wide;
    end
  end

  assign prod_d = op_a * op_b;

  // cell index from product, clamped to the last grid point
  logic [5:0]         si_calc, ai_calc;
  logic signed [31:0] slope_res, leg_res;

  always_comb begin
    if (qs_q <= 32'sd0) begin
      si_calc = '0;
    end else if (prod_q[66:32] > 35'(sn_m1)) begin
      si_calc = sn_m1[5:0];
    end else begin
      si_calc = prod_q[37:32];
    end
    if (qa_q <= 32'sd0) begin
      ai_calc = '0;
    end else if (prod_q[66:32] > 35'(an_m1)) begin
      ai_calc = an_m1[5:0];
    end else begin
      ai_calc = prod_q[37:32];
    end
  end

  assign slope_res = sat32(wide_q ? (prod_q >>> 17) : (prod_q >>> 16));
  assign leg_res   = sat32(prod_q >>> 16);

  // window of 4x4 grid entries around the root cell
  logic [3:0]  rd_pos, cp_pos;
  logic [7:0]  win_row, win_col;
  logic [12:0] win_addr;
  logic        win_ok;

  assign rd_pos   = 4'(step_q - STEP_RD0);
  assign cp_pos   = 4'(step_q - STEP_CP0);
  assign win_row  = 8'(si_q) + 8'(rd_pos[3:2]) - 8'd1;
  assign win_col  = 8'(ai_q) + 8'(rd_pos[1:0]) - 8'd1;
  assign win_addr = 13'(win_row[5:0]) * 13'(cfg_i.angle_n) + 13'(win_col[5:0]);
  assign win_ok   = (win_row < 8'(cfg_i.speed_n)) && (win_col < 8'(cfg_i.angle_n))
                    && ({1'b0, win_addr} < DEPTH_LIM);
  assign rd_addr_o = win_ok ? win_addr[AW-1:0] : '0;

  // highest address the query touches decides the range fault
  logic [6:0]  top_row, row_gap, top_col, si_p2, col_cand;
  logic [12:0] top_addr;
  logic        fault_d;

  always_comb begin
    si_p2    = 7'(si_q) + 7'd2;
    top_row  = (si_p2 <= sn_m1) ? si_p2 : sn_m1;
    row_gap  = top_row - 7'(si_q);
    col_cand = 7'(ai_q) + 7'd2 - row_gap;
    top_col  = (col_cand > an_m1) ? an_m1 : col_cand;
    top_addr = 13'(top_row[5:0]) * 13'(cfg_i.angle_n) + 13'(top_col[5:0]);
    fault_d  = ({1'b0, top_addr} >= DEPTH_LIM);
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    issue_q <= step_q;
    wide_q  <= wide_d;
    if (state_q == ST_IDLE && start_i) begin
      qs_q <= qs_i;
      qa_q <= qa_i;
    end
    if (state_q == ST_RUN && step_q == STEP_RD0) begin
      fault_q <= fault_d;
    end
    if (state_q == ST_RUN && step_q >= STEP_CP0 && step_q <= STEP_CP15) begin
      w_q[cp_pos] <= rd_data_i;
    end
    if (prod_vld_q) begin
      case (issue_q)
        STEP_SI:  si_q     <= si_calc;
        STEP_AI:  ai_q     <= ai_calc;
        STEP_FS:  fs_q     <= sat32(67'(qs_q) - prod_q);
        STEP_FA:  fa_q     <= sat32(67'(qa_q) - prod_q);
        STEP_CS0: cs_q[0]  <= slope_res;
        STEP_CS1: cs_q[1]  <= slope_res;
        STEP_CS2: cs_q[2]  <= slope_res;
        STEP_CA0: ca_q[0]  <= slope_res;
        STEP_CA1: ca_q[1]  <= slope_res;
        STEP_CA2: ca_q[2]  <= slope_res;
        STEP_L0A: ls_q[0]  <= leg_res;
        STEP_L0S: ls_q[1]  <= leg_res;
        STEP_L1A: ls_q[2]  <= leg_res;
        STEP_L1S: ls_q[3]  <= leg_res;
        STEP_L2A: ls_q[4]  <= leg_res;
        STEP_L2S: ls_q[5]  <= leg_res;
        STEP_T0A: t_q[0]   <= 48'(prod_q >>> 16);
        STEP_T0S: t_q[1]   <= 48'(prod_q >>> 16);
        STEP_T1A: t_q[2]   <= 48'(prod_q >>> 16);
        STEP_T1S: t_q[3]   <= 48'(prod_q >>> 16);
        STEP_T2A: t_q[4]   <= 48'(prod_q >>> 16);
        STEP_T2S: t_q[5]   <= 48'(prod_q >>> 16);
        default: ;
      endcase
    end
  end

  // root plus the legs that exist
  logic               leg_a_ok, leg_s_ok;
  logic signed [49:0] tot0, tot1, tot2;

  assign leg_a_ok = (7'(ai_q) + 7'd1 < cfg_i.angle_n);
  assign leg_s_ok = (7'(si_q) + 7'd1 < cfg_i.speed_n);

  assign tot0 = 50'(w_q[5]) + (leg_a_ok ? 50'(t_q[0]) : 50'sd0)
                + (leg_s_ok ? 50'(t_q[1]) : 50'sd0);
  assign tot1 = 50'(cs_q[0]) + (leg_a_ok ? 50'(t_q[2]) : 50'sd0)
                + (leg_s_ok ? 50'(t_q[3]) : 50'sd0);
  assign tot2 = 50'(ca_q[0]) + (leg_a_ok ? 50'(t_q[4]) : 50'sd0)
                + (leg_s_ok ? 50'(t_q[5]) : 50'sd0);

  always_comb begin
    result_o = '0;
    if (fault_q) begin
      result_o.status = STATUS_RANGE;
    end else begin
      result_o.status      = STATUS_OK;
      result_o.value_out   = sat32(67'(tot0));
      result_o.speed_slope = sat32(67'(tot1));
      result_o.angle_slope = sat32(67'(tot2));
    end
  end

  assign busy_o = (state_q == ST_RUN);
  assign done_o = (state_q == ST_RUN) && (step_q == STEP_FIN);

endmodule

// File: rtl/core/grid_table_interpolator.sv
// timing: a write or a query before the table is ready gives its result in the
//   cycle after acceptance; a query's result is registered at the engine's final step
// sequencing: no transaction is taken while a query runs; the 16 window reads share
//   the one grid memory read port and the 22 products share one multiplier
// reset: configuration returns to steps of 1.0, two samples per axis, table not ready;
//   the grid memory is not cleared and holds nothing valid until written
module grid_table_interpolator #(
  parameter int unsigned TABLE_DEPTH      = gti_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MAX_AXIS_SAMPLES = gti_pkg::DEF_MAX_AXIS_SAMPLES,
  localparam int unsigned AW              = $clog2(TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gti_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gti_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import gti_pkg::*;

  localparam logic [13:0] DEPTH_LIM = 14'(TABLE_DEPTH);
  localparam logic [6:0]  MAX_N     = 7'(MAX_AXIS_SAMPLES);

  // configuration registers, raw as written
  logic [30:0] speed_step_q, speed_inv_q, angle_step_q, angle_inv_q;
  logic [6:0]  speed_n_q, angle_n_q;
  logic        table_ready_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_step_q  <= 31'd65536;
      speed_inv_q   <= 31'd65536;
      angle_step_q  <= 31'd65536;
      angle_inv_q   <= 31'd65536;
      speed_n_q     <= 7'd2;
      angle_n_q     <= 7'd2;
      table_ready_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPEED_STEP:     speed_step_q  <= cfg_data_i[30:0];
        CFG_SPEED_STEP_INV: speed_inv_q   <= cfg_data_i[30:0];
        CFG_ANGLE_STEP:     angle_step_q  <= cfg_data_i[30:0];
        CFG_ANGLE_STEP_INV: angle_inv_q   <= cfg_data_i[30:0];
        CFG_SPEED_SAMPLES:  speed_n_q     <= cfg_data_i[6:0];
        CFG_ANGLE_SAMPLES:  angle_n_q     <= cfg_data_i[6:0];
        CFG_TABLE_READY:    table_ready_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sanitized geometry: zero steps and inverses act as one LSB, sample counts clamped
  axis_cfg_t geo;

  always_comb begin
    geo.speed_step = (speed_step_q == '0) ? 31'd1 : speed_step_q;
    geo.speed_inv  = (speed_inv_q == '0) ? 31'd1 : speed_inv_q;
    geo.angle_step = (angle_step_q == '0) ? 31'd1 : angle_step_q;
    geo.angle_inv  = (angle_inv_q == '0) ? 31'd1 : angle_inv_q;
    geo.speed_n    = (speed_n_q < 7'd2) ? 7'd2 : ((speed_n_q > MAX_N) ? MAX_N : speed_n_q);
    geo.angle_n    = (angle_n_q < 7'd2) ? 7'd2 : ((angle_n_q > MAX_N) ? MAX_N : angle_n_q);
  end

  // input transaction handshake; the result register frees as it drains
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      eng_busy, eng_done, eng_start;
  out_item_t eng_result;
  logic      in_accept, is_query;

  assign in_ready_o = !eng_busy && (!out_valid_q || out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_query   = (in_item_i.cmd == CMD_QUERY);
  assign eng_start  = in_accept && is_query && table_ready_q;

  // grid write: address is speed index times angle samples plus angle index
  logic [12:0]   wr_addr;
  logic          wr_ok, ram_we;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  assign wr_addr = 13'(in_item_i.entry_speed_index) * 13'(geo.angle_n)
                   + 13'(in_item_i.entry_angle_index);
  assign wr_ok   = (7'(in_item_i.entry_speed_index) < geo.speed_n)
                   && (7'(in_item_i.entry_angle_index) < geo.angle_n)
                   && ({1'b0, wr_addr} < DEPTH_LIM);
  assign ram_we  = in_accept && !is_query && wr_ok;

  gti_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr[AW-1:0]),
    .wdata_i (in_item_i.entry_value),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  gti_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .qs_i      (in_item_i.query_speed),
    .qa_i      (in_item_i.query_angle),
    .cfg_i     (geo),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .busy_o    (eng_busy),
    .done_o    (eng_done),
    .result_o  (eng_result)
  );

  // immediate result for writes and for queries before the table is ready
  out_item_t quick_result;

  always_comb begin
    quick_result = '0;
    if (is_query) begin
      quick_result.status = STATUS_NOT_READY;
    end else if (!wr_ok) begin
      quick_result.status = STATUS_RANGE;
    end else begin
      quick_result.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_done || (in_accept && !eng_start)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done) begin
      out_item_q <= eng_result;
    end else if (in_accept && !eng_start) begin
      out_item_q <= quick_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a finished query must find the result register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) eng_done |-> !out_valid_q)
    else $error("query result would overwrite a pending transaction");

  // a started query keeps the engine busy on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) eng_start |=> eng_busy)
    else $error("engine did not start");

  // grid writes never overlap the window reads of a query
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !eng_busy)
    else $error("grid write during query");

endmodule

// File: test/gti_checker.sv
module gti_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  gti_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  gti_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 err_cnt_o,
  output int                 pending_o
);
  import gti_pkg::*;

  localparam int unsigned DEPTH = DEF_TABLE_DEPTH;

  logic [30:0] speed_step_q, speed_inv_q, angle_step_q, angle_inv_q;
  logic [6:0]  speed_n_q, angle_n_q;
  logic        ready_q;

  int          grid_mem [DEPTH];
  out_item_t   expected_q [$];
  int          err_cnt;
  int          pend_cnt;

  // per-query geometry
  longint      sn, an, s_inv, a_inv;
  bit          addr_fault;

  assign err_cnt_o = err_cnt;
  assign pending_o = pend_cnt;

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint read_grid(longint s, longint a);
    longint addr;
    addr = s * an + a;
    if (addr >= DEPTH) begin
      addr_fault = 1'b1;
      return 0;
    end
    return longint'(grid_mem[addr]);
  endfunction

  function automatic longint diff(longint hi, longint lo, longint inv, int sh);
    return sat(((hi - lo) * inv) >>> sh);
  endfunction

  // kind 0 value, 1 speed slope, 2 angle slope
  function automatic longint node(int kind, longint s, longint a);
    if (kind == 0) return read_grid(s, a);
    if (kind == 1) begin
      if (s == 0) return diff(read_grid(1, a), read_grid(0, a), s_inv, 16);
      if (s == sn - 1) return diff(read_grid(s, a), read_grid(s - 1, a), s_inv, 16);
      return diff(read_grid(s + 1, a), read_grid(s - 1, a), s_inv, 17);
    end
    if (a == 0) return diff(read_grid(s, 1), read_grid(s, 0), a_inv, 16);
    if (a == an - 1) return diff(read_grid(s, a), read_grid(s, a - 1), a_inv, 16);
    return diff(read_grid(s, a + 1), read_grid(s, a - 1), a_inv, 17);
  endfunction

  function automatic longint blend(int kind, longint si, longint ai,
                                   longint fs, longint fa);
    longint root, total;
    root  = node(kind, si, ai);
    total = root;
    // legs past the last grid point are dropped
    if (ai + 1 < an) total += (diff(node(kind, si, ai + 1), root, a_inv, 16) * fa) >>> 16;
    if (si + 1 < sn) total += (diff(node(kind, si + 1, ai), root, s_inv, 16) * fs) >>> 16;
    return sat(total);
  endfunction

  function automatic longint cell_of(longint q, longint inv, longint n);
    longint p;
    if (q <= 0) return 0;
    p = (q * inv) >>> 32;
    return (p > n - 1) ? n - 1 : p;
  endfunction

  function automatic longint clamp_n(logic [6:0] r);
    if (r < 2) return 2;
    if (r > DEF_MAX_AXIS_SAMPLES) return DEF_MAX_AXIS_SAMPLES;
    return longint'(r);
  endfunction

  function automatic longint nz(logic [30:0] r);
    return (r == '0) ? 1 : longint'(r);
  endfunction

  function automatic out_item_t predict_lookup(in_item_t it);
    out_item_t r;
    longint    s, a, addr, qs, qa, si, ai, fs, fa, v, ds, da;
    r     = '0;
    sn    = clamp_n(speed_n_q);
    an    = clamp_n(angle_n_q);
    s_inv = nz(speed_inv_q);
    a_inv = nz(angle_inv_q);
    if (it.cmd == CMD_WRITE) begin
      s    = longint'(it.entry_speed_index);
      a    = longint'(it.entry_angle_index);
      addr = s * an + a;
      if (s >= sn || a >= an || addr >= DEPTH) r.status = STATUS_RANGE;
      else grid_mem[addr] = it.entry_value;
      return r;
    end
    if (!ready_q) begin
      r.status = STATUS_NOT_READY;
      return r;
    end
    qs = longint'(it.query_speed);
    qa = longint'(it.query_angle);
    si = cell_of(qs, s_inv, sn);
    ai = cell_of(qa, a_inv, an);
    fs = sat(qs - si * nz(speed_step_q));
    fa = sat(qa - ai * nz(angle_step_q));
    addr_fault = 1'b0;
    v  = blend(0, si, ai, fs, fa);
    ds = blend(1, si, ai, fs, fa);
    da = blend(2, si, ai, fs, fa);
    if (addr_fault) begin
      r.status = STATUS_RANGE;
      return r;
    end
    r.status      = STATUS_OK;
    r.value_out   = v[31:0];
    r.speed_slope = ds[31:0];
    r.angle_slope = da[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      speed_step_q <= 31'd65536;
      speed_inv_q  <= 31'd65536;
      angle_step_q <= 31'd65536;
      angle_inv_q  <= 31'd65536;
      speed_n_q    <= 7'd2;
      angle_n_q    <= 7'd2;
      ready_q      <= 1'b0;
      err_cnt      <= 0;
      pend_cnt     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPEED_STEP:     speed_step_q <= cfg_data_i[30:0];
          CFG_SPEED_STEP_INV: speed_inv_q  <= cfg_data_i[30:0];
          CFG_ANGLE_STEP:     angle_step_q <= cfg_data_i[30:0];
          CFG_ANGLE_STEP_INV: angle_inv_q  <= cfg_data_i[30:0];
          CFG_SPEED_SAMPLES:  speed_n_q    <= cfg_data_i[6:0];
          CFG_ANGLE_SAMPLES:  angle_n_q    <= cfg_data_i[6:0];
          CFG_TABLE_READY:    ready_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_lookup(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (err_cnt < 10) $display("unexpected result %p", out_item_i);
          err_cnt <= err_cnt + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item !== out_item_i) begin
            if (err_cnt < 10) $display("result differs: exp %p got %p", exp_item, out_item_i);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      pend_cnt <= expected_q.size();
    end
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  import gti_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NPHASE         = 5;
  localparam int RAND_PER_PHASE = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  int err_cnt, pending;
  int send_idle_pct, recv_idle_pct;
  bit hold_recv;
  int stall_cnt;

  // per-phase geometry: zero steps, wide inverses and odd sample counts included
  longint ph_sstep [NPHASE] = '{65536, 32768, 64'h4000_0000, 0, 65536};
  longint ph_sinv  [NPHASE] = '{65536, 131072, 4, 0, 64'h7fff_ffff};
  longint ph_astep [NPHASE] = '{65536, 196608, 1, 64'hffff_ffff, 65536};
  longint ph_ainv  [NPHASE] = '{65536, 21845, 64'h7fff_ffff, 0, 65536};
  int     ph_sn    [NPHASE] = '{2, 8, 10, 127, 64};
  int     ph_an    [NPHASE] = '{2, 5, 6, 1, 64};

  always #4 clk_i = ~clk_i;

  grid_table_interpolator u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  gti_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // receiver: random backpressure, plus a long hold-off when asked
  always @(posedge clk_i) begin
    out_ready_i <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("grid_table_interpolator: mismatch");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // one transaction; valid stays high afterwards until the next gap or the end
  task automatic send_item(in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic write_entry(int s, int a, logic [31:0] v);
    in_item_t it;
    it                   = '0;
    it.cmd               = CMD_WRITE;
    it.entry_speed_index = s[5:0];
    it.entry_angle_index = a[5:0];
    it.entry_value       = v;
    it.query_speed       = $urandom();
    it.query_angle       = $urandom();
    send_item(it);
  endtask

  task automatic query_point(logic [31:0] qs, logic [31:0] qa);
    in_item_t it;
    it             = '0;
    it.cmd         = CMD_QUERY;
    it.entry_speed_index = 6'($urandom());
    it.entry_angle_index = 6'($urandom());
    it.entry_value = $urandom();
    it.query_speed = qs;
    it.query_angle = qa;
    send_item(it);
  endtask

  // config writes are issued back to back; valid drops once after the batch
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  // pending count is sampled away from the clock edge where it changes
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(longint extent);
    int     r;
    longint top;
    r   = $urandom_range(0, 99);
    top = (extent > 64'sd2147483647) ? 64'sd2147483647 : extent;
    if (r < 70) return 32'($urandom_range(0, 32'(top)));
    if (r < 85) return -32'($urandom_range(0, 200000));
    return $urandom();
  endfunction

  initial begin
    int sn, an;
    logic [31:0] v;
    hold_recv     = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 72;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table not ready, write an extreme value and out of range indexes
    query_point(32'd65536, 32'd65536);
    write_entry(0, 0, 32'h7fff_ffff);
    write_entry(63, 0, 32'h1234_5678);
    write_entry(0, 63, 32'h8765_4321);

    for (int p = 0; p < NPHASE; p++) begin
      drain();
      // receiver-heavy idling, then sender-heavy, then none
      if (p < 2) begin
        send_idle_pct = 10; recv_idle_pct = 72;
      end else if (p < 3) begin
        send_idle_pct = 72; recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      cfg_write(CFG_TABLE_READY, 32'd0);
      cfg_write(CFG_SPEED_STEP, 32'(ph_sstep[p]));
      cfg_write(CFG_SPEED_STEP_INV, 32'(ph_sinv[p]));
      cfg_write(CFG_ANGLE_STEP, 32'(ph_astep[p]));
      cfg_write(CFG_ANGLE_STEP_INV, 32'(ph_ainv[p]));
      cfg_write(CFG_SPEED_SAMPLES, 32'(ph_sn[p]));
      cfg_write(CFG_ANGLE_SAMPLES, 32'(ph_an[p]));
      cfg_valid_i <= 1'b0;
      sn = (ph_sn[p] < 2) ? 2 : (ph_sn[p] > 64) ? 64 : ph_sn[p];
      an = (ph_an[p] < 2) ? 2 : (ph_an[p] > 64) ? 64 : ph_an[p];

      // load every reachable entry so no query reads an unwritten one;
      // the last phase only queries cells past the store, so nothing is loaded
      for (int s = 0; s < sn; s++) begin
        for (int a = 0; a < an; a++) begin
          if (p != NPHASE - 1 && s * an + a < DEF_TABLE_DEPTH) begin
            if (p == 0) v = ((s + a) % 2 == 0) ? 32'h7fff_ffff : 32'h8000_0000;
            else if ($urandom_range(0, 3) == 0) v = $urandom();
            else v = 32'($urandom_range(0, 2000000)) - 32'd1000000;
            write_entry(s, a, v);
          end
        end
      end
      drain();
      cfg_write(CFG_TABLE_READY, 32'd1);
      cfg_valid_i <= 1'b0;

      if (p == 0) begin
        // corner, middle, negative extrapolation, saturation extremes
        query_point(32'd0, 32'd0);
        query_point(32'd65536, 32'd65536);
        query_point(32'd32768, 32'd16384);
        query_point(-32'sd196608, -32'sd32768);
        query_point(32'h7fff_ffff, 32'h7fff_ffff);
        query_point(32'h8000_0000, 32'h8000_0000);
        query_point(32'h8000_0000, 32'h7fff_ffff);
        query_point(32'd65536, 32'd0);
        query_point(32'd0, 32'd65536);
      end

      if (p == 1) begin
        // long receiver hold-off while queries keep coming
        fork
          begin
            hold_recv = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_recv = 1'b0;
          end
        join_none
      end

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0)
            write_entry($urandom_range(0, sn - 1), $urandom_range(0, an - 1), $urandom());
          else
            write_entry($urandom_range(0, 63), $urandom_range(0, 63), $urandom());
        end else if (p == NPHASE - 1) begin
          // speed clamps to the last row, whose entries lie past the store
          query_point(32'($urandom_range(32'h0010_0000, 32'h7fff_ffff)),
                      pick_coord(longint'(an) * ph_astep[p]));
        end else begin
          query_point(pick_coord(longint'(sn) * ph_sstep[p]),
                      pick_coord(longint'(an) * ph_astep[p]));
        end
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("grid_table_interpolator: match");
    end else begin
      $display("grid_table_interpolator: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/gti_pkg.sv
rtl/core/gti_ram.sv
rtl/core/gti_engine.sv
rtl/core/grid_table_interpolator.sv
test/gti_checker.sv
test/tb_top.sv
